// ===== hw/rtl/mrx_pkg.sv =====
// shared constants, decoded request and result types for the execute unit
package mrx_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REG_COUNT = 32;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int XLEN      = 32;
  localparam int PC_W      = 13;
  localparam int IMM_W     = 13;
  localparam int MADDR_W   = 12;
  localparam int Q_DEPTH   = 2;
  localparam int QPW       = $clog2(Q_DEPTH);
  localparam int QCW       = $clog2(Q_DEPTH + 1);

  // opcode field values
  localparam logic [3:0] OPC_ADD   = 4'd1;
  localparam logic [3:0] OPC_SUB   = 4'd2;
  localparam logic [3:0] OPC_ADDI  = 4'd3;
  localparam logic [3:0] OPC_SLLI  = 4'd4;
  localparam logic [3:0] OPC_SRLI  = 4'd5;
  localparam logic [3:0] OPC_LI    = 4'd6;
  localparam logic [3:0] OPC_LW    = 4'd7;
  localparam logic [3:0] OPC_SW    = 4'd8;
  localparam logic [3:0] OPC_BNE   = 4'd9;
  localparam logic [3:0] OPC_BEQ   = 4'd10;
  localparam logic [3:0] OPC_BLE   = 4'd11;
  localparam logic [3:0] OPC_BGT   = 4'd12;
  localparam logic [3:0] OPC_J     = 4'd13;
  localparam logic [3:0] OPC_ECALL = 4'd14;

  // rs2 value that turns lw into la
  localparam logic [3:0] LA_MARK = 4'd15;

  localparam logic [REG_AW-1:0] REG_A0 = REG_AW'(10);
  localparam logic [REG_AW-1:0] REG_A7 = REG_AW'(17);

  localparam logic [XLEN-1:0] ECALL_PRINT_INT = XLEN'(1);
  localparam logic [XLEN-1:0] ECALL_PRINT_STR = XLEN'(4);

  localparam logic [1:0] PRINT_NONE = 2'd0;
  localparam logic [1:0] PRINT_INT  = 2'd1;
  localparam logic [1:0] PRINT_STR  = 2'd2;

  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_ADD,
    UOP_SUB,
    UOP_ADDI,
    UOP_SLLI,
    UOP_SRLI,
    UOP_LI,
    UOP_LW,
    UOP_LA,
    UOP_SW,
    UOP_BNE,
    UOP_BEQ,
    UOP_BLE,
    UOP_BGT,
    UOP_J,
    UOP_ECALL,
    UOP_PRELOAD
  } uop_t;

  typedef struct packed {
    uop_t              uop;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] rs1;
    logic [REG_AW-1:0] rsb;
    logic [IMM_W-1:0]  imm;
    logic [11:0]       load_address;
    logic [XLEN-1:0]   load_value;
  } uop_entry_t;

  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               retired;
    logic               reg_write_en;
    logic [REG_AW-1:0]  reg_write_index;
    logic [XLEN-1:0]    reg_write_value;
    logic               mem_write_en;
    logic [MADDR_W-1:0] mem_address;
    logic [XLEN-1:0]    mem_write_value;
    logic [1:0]         print_kind;
    logic [XLEN-1:0]    print_value;
  } result_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_LOAD
  } back_state_t;

endpackage

// ===== hw/rtl/mrx_front.sv =====
// front end: request acceptance and instruction classification
module mrx_front (
  input  logic               clearing,
  input  logic               q_full,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [30:0]        in_instr_word,
  input  logic [11:0]        in_load_address,
  input  logic signed [31:0] in_load_value,
  output logic               push,
  output mrx_pkg::uop_entry_t push_entry
);
  import mrx_pkg::*;

  logic [3:0] opc;
  logic [3:0] rs2;

  assign opc = in_instr_word[30:27];
  assign rs2 = in_instr_word[16:13];

  assign in_ready = !clearing && !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_entry.uop          = UOP_NOP;
    push_entry.rd           = in_instr_word[26:22];
    push_entry.rs1          = in_instr_word[21:17];
    push_entry.rsb          = REG_AW'(rs2);
    push_entry.imm          = in_instr_word[IMM_W-1:0];
    push_entry.load_address = in_load_address;
    push_entry.load_value   = in_load_value;
    if (in_mode) begin
      push_entry.uop = UOP_PRELOAD;
    end else begin
      case (opc)
        OPC_ADD:   push_entry.uop = UOP_ADD;
        OPC_SUB:   push_entry.uop = UOP_SUB;
        OPC_ADDI:  push_entry.uop = UOP_ADDI;
        OPC_SLLI:  push_entry.uop = UOP_SLLI;
        OPC_SRLI:  push_entry.uop = UOP_SRLI;
        OPC_LI:    push_entry.uop = UOP_LI;
        OPC_LW:    push_entry.uop = (rs2 == LA_MARK) ? UOP_LA : UOP_LW;
        OPC_SW: begin
          // store data comes from rd, read on the second port
          push_entry.uop = UOP_SW;
          push_entry.rsb = in_instr_word[26:22];
        end
        OPC_BNE:   push_entry.uop = UOP_BNE;
        OPC_BEQ:   push_entry.uop = UOP_BEQ;
        OPC_BLE:   push_entry.uop = UOP_BLE;
        OPC_BGT:   push_entry.uop = UOP_BGT;
        OPC_J:     push_entry.uop = UOP_J;
        OPC_ECALL: push_entry.uop = UOP_ECALL;
        default:   push_entry.uop = UOP_NOP;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mrx_queue.sv =====
// short fifo of decoded requests between front and back
module mrx_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mrx_pkg::uop_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output mrx_pkg::uop_entry_t head_entry
);
  import mrx_pkg::*;

  uop_entry_t     slots_r [Q_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full       = (cnt_r == QCW'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/mrx_back.sv =====
// back end: register file, data memory, execute stage and result register
module mrx_back (
  input  logic                clk,
  input  logic                rst_n,
  output logic                clearing,
  input  logic                q_valid,
  input  mrx_pkg::uop_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mrx_pkg::result_t    out_result
);
  import mrx_pkg::*;

  logic [XLEN-1:0]   regs_mem [REG_COUNT];
  logic [XLEN-1:0]   dmem     [MEM_WORDS];

  back_state_t       st_r, st_nxt;
  logic [MEM_AW-1:0] clr_r;
  logic [PC_W-1:0]   pc_r;
  logic              out_valid_r;
  result_t           out_r, res_nxt;
  uop_entry_t        e_r;
  logic [XLEN-1:0]   rd_a_r, rd_b_r;
  logic [XLEN-1:0]   ld_data_r;
  logic [XLEN-1:0]   x10_r, x17_r;
  logic              byp_en_r;
  logic [REG_AW-1:0] byp_idx_r;
  logic [XLEN-1:0]   byp_val_r;

  logic              can_out, fire, issue_ld;
  logic [XLEN-1:0]   a, b, res;
  logic [MEM_AW-1:0] ea, maddr;
  logic              wreg, take, men, rf_we;
  logic [XLEN-1:0]   mval;
  logic [PC_W-1:0]   npc;
  logic [1:0]        pkind;

  assign clearing   = (st_r == BK_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;
  assign can_out    = !out_valid_r || out_ready;

  // operands, with the write retired at the read edge bypassed in
  assign a  = (byp_en_r && byp_idx_r == e_r.rs1) ? byp_val_r : rd_a_r;
  assign b  = (byp_en_r && byp_idx_r == e_r.rsb) ? byp_val_r : rd_b_r;
  assign ea = MEM_AW'(a) + MEM_AW'(e_r.imm >> 2);

  always_comb begin
    wreg  = 1'b0;
    take  = 1'b0;
    men   = 1'b0;
    res   = '0;
    maddr = '0;
    mval  = '0;
    pkind = PRINT_NONE;
    npc   = pc_r + PC_W'(1);
    case (e_r.uop)
      UOP_ADD: begin
        wreg = 1'b1;
        res  = a + b;
      end
      UOP_SUB: begin
        wreg = 1'b1;
        res  = a - b;
      end
      UOP_ADDI: begin
        wreg = 1'b1;
        res  = a + XLEN'(e_r.imm);
      end
      UOP_SLLI: begin
        wreg = 1'b1;
        res  = (e_r.imm[IMM_W-1:5] != '0) ? '0 : a << e_r.imm[4:0];
      end
      UOP_SRLI: begin
        wreg = 1'b1;
        res  = (e_r.imm[IMM_W-1:5] != '0) ? '0 : a >> e_r.imm[4:0];
      end
      UOP_LI, UOP_LA: begin
        wreg = 1'b1;
        res  = XLEN'(e_r.imm);
      end
      UOP_LW: begin
        wreg  = 1'b1;
        res   = ld_data_r;
        maddr = ea;
      end
      UOP_SW: begin
        men   = 1'b1;
        maddr = ea;
        mval  = b;
      end
      UOP_BNE:  take = (a != b);
      UOP_BEQ:  take = (a == b);
      UOP_BLE:  take = ($signed(a) <= $signed(b));
      UOP_BGT:  take = ($signed(a) > $signed(b));
      UOP_J:    take = 1'b1;
      UOP_ECALL: begin
        if (x17_r == ECALL_PRINT_INT) begin
          pkind = PRINT_INT;
        end else if (x17_r == ECALL_PRINT_STR) begin
          pkind = PRINT_STR;
        end
      end
      UOP_PRELOAD: begin
        men   = 1'b1;
        maddr = MEM_AW'(e_r.load_address);
        mval  = e_r.load_value;
        npc   = pc_r;
      end
      default: begin
      end
    endcase
    if (take) begin
      npc = e_r.imm[PC_W-1:0];
    end
    rf_we = wreg && (e_r.rd != '0);

    res_nxt.next_pc         = npc;
    res_nxt.retired         = (e_r.uop != UOP_NOP) && (e_r.uop != UOP_PRELOAD);
    res_nxt.reg_write_en    = rf_we;
    res_nxt.reg_write_index = rf_we ? e_r.rd : '0;
    res_nxt.reg_write_value = rf_we ? res : '0;
    res_nxt.mem_write_en    = men;
    res_nxt.mem_address     = MADDR_W'(maddr);
    res_nxt.mem_write_value = mval;
    res_nxt.print_kind      = pkind;
    res_nxt.print_value     = (pkind != PRINT_NONE) ? x10_r : '0;
  end

  // sequencing of the execute stage
  always_comb begin
    st_nxt   = st_r;
    issue_ld = (st_r == BK_EXEC) && (e_r.uop == UOP_LW);
    fire     = ((st_r == BK_EXEC) && (e_r.uop != UOP_LW) && can_out) ||
               ((st_r == BK_LOAD) && can_out);
    q_pop    = q_valid && ((st_r == BK_IDLE) || fire);
    case (st_r)
      BK_CLEAR: begin
        if (clr_r == MEM_AW'(MEM_WORDS - 1)) begin
          st_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_pop) begin
          st_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (issue_ld) begin
          st_nxt = BK_LOAD;
        end else if (fire) begin
          st_nxt = q_pop ? BK_EXEC : BK_IDLE;
        end
      end
      BK_LOAD: begin
        if (fire) begin
          st_nxt = q_pop ? BK_EXEC : BK_IDLE;
        end
      end
      default: st_nxt = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_CLEAR;
      clr_r       <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      x10_r       <= '0;
      x17_r       <= '0;
      byp_en_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_CLEAR) begin
        clr_r <= clr_r + MEM_AW'(1);
      end
      if (fire) begin
        pc_r <= npc;
      end
      out_valid_r <= fire || (out_valid_r && !out_ready);
      if (fire && rf_we && e_r.rd == REG_A0) begin
        x10_r <= res;
      end
      if (fire && rf_we && e_r.rd == REG_A7) begin
        x17_r <= res;
      end
      if (q_pop) begin
        byp_en_r <= fire && rf_we;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_r       <= q_entry;
      byp_idx_r <= e_r.rd;
      byp_val_r <= res;
    end
    if (fire) begin
      out_r <= res_nxt;
    end
  end

  // register file and data memory
  always_ff @(posedge clk) begin
    if (st_r == BK_CLEAR) begin
      dmem[clr_r]                   <= '0;
      regs_mem[clr_r[REG_AW-1:0]]   <= '0;
    end else begin
      if (fire && men) begin
        dmem[maddr] <= mval;
      end
      if (fire && rf_we) begin
        regs_mem[e_r.rd] <= res;
      end
    end
    if (issue_ld) begin
      ld_data_r <= dmem[ea];
    end
    if (q_pop) begin
      rd_a_r <= regs_mem[q_entry.rs1];
      rd_b_r <= regs_mem[q_entry.rsb];
    end
  end

endmodule

// ===== hw/rtl/mini_riscv_execute_unit.sv =====
// top level of the execute unit: front end, request queue and back end
//
//   channel   handshake               payload
//   in_       in_valid / in_ready     mode, instr_word, load_address, load_value
//   out_      out_valid / out_ready   next_pc, retired, reg_write_*, mem_*, print_*
//
// one request per cycle sustained while out_ready is high; a load holds the execute
// stage in BK_LOAD too, as the data memory read port has registered read data
// results pass a queue slot, e_r and out_r, and a load's data also passes ld_data_r
// after reset the data memory and register file are swept to zero, one word
// per cycle, over all MEM_WORDS addresses (4096); in_ready stays low during the sweep
// a stalled out_ready backs up the execute stage, then the 2-entry queue,
// and only then drops in_ready
module mini_riscv_execute_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [30:0]        in_instr_word,
  input  logic [11:0]        in_load_address,
  input  logic signed [31:0] in_load_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [12:0]        out_next_pc,
  output logic               out_retired,
  output logic               out_reg_write_en,
  output logic [4:0]         out_reg_write_index,
  output logic signed [31:0] out_reg_write_value,
  output logic               out_mem_write_en,
  output logic [11:0]        out_mem_address,
  output logic signed [31:0] out_mem_write_value,
  output logic [1:0]         out_print_kind,
  output logic signed [31:0] out_print_value
);
  import mrx_pkg::*;

  // front to queue
  logic       clearing;
  logic       q_full;
  logic       push;
  uop_entry_t push_entry;

  // queue to back
  logic       q_valid;
  logic       q_pop;
  uop_entry_t q_entry;

  result_t    result;

  // accepts requests and classifies each into a decoded micro-op
  mrx_front u_front (
    .clearing        (clearing),
    .q_full          (q_full),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_instr_word   (in_instr_word),
    .in_load_address (in_load_address),
    .in_load_value   (in_load_value),
    .push            (push),
    .push_entry      (push_entry)
  );

  // decouples acceptance from execution so each side stalls on its own
  mrx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_entry)
  );

  // register read on pop, execute, memory access and result register
  mrx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clearing   (clearing),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  // result fields onto the output ports
  assign out_next_pc         = result.next_pc;
  assign out_retired         = result.retired;
  assign out_reg_write_en    = result.reg_write_en;
  assign out_reg_write_index = result.reg_write_index;
  assign out_reg_write_value = result.reg_write_value;
  assign out_mem_write_en    = result.mem_write_en;
  assign out_mem_address     = result.mem_address;
  assign out_mem_write_value = result.mem_write_value;
  assign out_print_kind      = result.print_kind;
  assign out_print_value     = result.print_value;

endmodule
